FILE: rtl/neuron_mac_inverse_square_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef NEURON_MAC_INVERSE_SQUARE_MACROS_SVH
`define NEURON_MAC_INVERSE_SQUARE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMIS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NMIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nmis_pkg.sv
`default_nettype none

package nmis_pkg;

  // Field and datapath widths.
  localparam int DATA_W    = 16;
  localparam int ACC_W     = 48;
  localparam int FRAC_BITS = 12;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int OUT_W     = 17;

  // Inverse-square arithmetic: magnitude window, squared term, divider.
  localparam int MAG_HI    = 33;
  localparam int MAG_LO    = 8;
  localparam int T_W       = MAG_HI - MAG_LO;
  localparam int SQ_W      = 2 * T_W;
  localparam int QUOT_BITS = OUT_W;
  localparam int CNT_W     = $clog2(QUOT_BITS);

  // One in Q.32 (divisor offset) and one in Q.48 (dividend).
  localparam logic [SQ_W-1:0] ONE_Q32 = SQ_W'(1) << 32;
  localparam logic [SQ_W-1:0] ONE_Q48 = SQ_W'(1) << 48;
  // Squared sums above this limit give a zero result.
  localparam logic [SQ_W-1:0] SQ_LIMIT = SQ_W'(1) << 49;

  // Input beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] act_in;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] bias;
    logic                     first;
    logic                     last;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [OUT_W-1:0] act_out;
    logic             saturated;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mac_en;
    logic abs_en;
    logic sq_en;
    logic prep_en;
    logic div_en;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/neuron_mac_inverse_square.sv
`default_nettype none

// Single-neuron forward pass with an inverse-square activation.
// Input channel (in_valid / in_stall / in_data): one activation and weight per
// beat; a beat with first set restarts the sum from its bias, and a beat with
// last set requests a result. Result channel (out_valid / out_stall /
// out_data): act_out = 1/(1+s*s) in unsigned Q1.16 plus the clip flag.
// Beats without last are taken as they come, so a node streams one beat per
// cycle. After a last beat the input stalls while the magnitude, square and a
// 17-step restoring divider run: out_valid rises once the result is loaded,
// and the input is free again in the same cycle. The divider produces one
// quotient bit per cycle.
// The result sits in an output register; if the receiver still stalls a
// previous result, the new one waits in the divider and the input stays
// stalled until the register is free.
// Synchronous reset clears the accumulator and clip flag, empties the output
// register and leaves the block ready for input.
module neuron_mac_inverse_square (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire nmis_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output nmis_pkg::out_beat_t      out_data
);

  nmis_pkg::cmd_t cmd;

  // Sequencer.
  nmis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Accumulator, squarer, divider and output register.
  nmis_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/nmis_ctrl.sv
`default_nettype none

module nmis_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  input  wire logic          out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output nmis_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ABS  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [nmis_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       in_acc;

  // Items are taken only while no activation is being computed.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && (state_r == S_IDLE);

  // Sequencer: accumulate, then magnitude, square, setup, divide, hand off.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mac_en   = in_acc;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_last) begin
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep_en = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == nmis_pkg::CNT_W'(nmis_pkg::QUOT_BITS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register is full from load until the receiver takes the beat.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nmis_dp.sv
`default_nettype none

module nmis_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nmis_pkg::cmd_t      cmd,
  input  wire nmis_pkg::in_beat_t  in_data,
  output nmis_pkg::out_beat_t      out_data
);

  localparam int ACC_W  = nmis_pkg::ACC_W;
  localparam int SQ_W   = nmis_pkg::SQ_W;
  localparam int T_W    = nmis_pkg::T_W;
  localparam int OUT_W  = nmis_pkg::OUT_W;
  localparam int DATA_W = nmis_pkg::DATA_W;
  localparam int PROD_W = nmis_pkg::PROD_W;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              clip_r, clip_nxt;
  logic [T_W-1:0]    t_r;
  logic              big_r;
  logic [SQ_W-1:0]   q_r;
  logic              zero_r;
  logic [SQ_W-1:0]   d_r;
  logic [SQ_W-1:0]   rem_r, rem_nxt;
  logic [OUT_W-1:0]  nq_r, nq_nxt;
  nmis_pkg::out_beat_t out_r;

  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         bias_ext;
  logic [ACC_W-1:0]         base;
  logic [ACC_W:0]           sum;
  logic                     ovf;
  logic [ACC_W-1:0]         mag;
  logic [SQ_W-1:0]          d_val;
  logic [SQ_W-1:0]          num;
  logic [SQ_W+1:0]          diff;
  logic [SQ_W:0]            shifted;
  logic                     ge;

  // Multiply-accumulate with saturation; a first beat restarts from the bias.
  always_comb begin
    prod     = in_data.act_in * in_data.weight;
    bias_ext = {{(ACC_W-DATA_W){in_data.bias[DATA_W-1]}}, in_data.bias};
    base     = in_data.first ? (bias_ext << nmis_pkg::FRAC_BITS) : acc_r;
    sum      = {base[ACC_W-1], base} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
    ovf      = sum[ACC_W] ^ sum[ACC_W-1];
    acc_nxt  = ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
    clip_nxt = (!in_data.first && clip_r) || ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      clip_r <= 1'b0;
    end else if (cmd.mac_en) begin
      acc_r  <= acc_nxt;
      clip_r <= clip_nxt;
    end
  end

  // Magnitude of the sum; the abs step truncates it to 16 fraction bits.
  assign mag = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;

  // Divisor 1 + s*s in Q.32 and the dividend, one in Q.48 plus half the divisor for rounding.
  assign d_val = q_r + nmis_pkg::ONE_Q32;
  assign num   = nmis_pkg::ONE_Q48 + {1'b0, d_val[SQ_W-1:1]};

  // One restoring division step: bring down a dividend bit, try a subtract.
  always_comb begin
    shifted = {rem_r, nq_r[OUT_W-1]};
    diff    = {1'b0, shifted} - {2'b00, d_r};
    ge      = !diff[SQ_W+1];
    rem_nxt = ge ? diff[SQ_W-1:0] : shifted[SQ_W-1:0];
    nq_nxt  = {nq_r[OUT_W-2:0], ge};
  end

  // Inverse-square pipeline registers, advanced by controller commands.
  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      t_r   <= mag[nmis_pkg::MAG_HI-1:nmis_pkg::MAG_LO];
      big_r <= |mag[ACC_W-1:nmis_pkg::MAG_HI];
    end
    if (cmd.sq_en) begin
      q_r <= t_r * t_r;
    end
    if (cmd.prep_en) begin
      zero_r <= big_r || (q_r > nmis_pkg::SQ_LIMIT);
      d_r    <= d_val;
      rem_r  <= {{OUT_W{1'b0}}, num[SQ_W-1:OUT_W]};
      nq_r   <= num[OUT_W-1:0];
    end else if (cmd.div_en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
    if (cmd.out_load) begin
      out_r.act_out   <= zero_r ? '0 : nq_r;
      out_r.saturated <= clip_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: rtl/nmis_chk.sv
`default_nettype none

`include "neuron_mac_inverse_square_macros.svh"

module nmis_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire nmis_pkg::in_beat_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire nmis_pkg::out_beat_t out_data
);

  // A stalled result beat stays valid and unchanged.
  `NMIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

  // The activation never exceeds one.
  `NMIS_ASSERT_NOW(a_out_range, clk, rst_n, out_valid, out_data.act_out <= 17'd65536, "act_out above one")

  // A final beat starts the activation, so the input stalls next cycle.
  `NMIS_ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && !in_stall && in_data.last, in_stall, "input not stalled after final beat")

  // Accumulating beats stream at one per cycle.
  `NMIS_ASSERT_NEXT(a_mac_stream, clk, rst_n, in_valid && !in_stall && !in_data.last, !in_stall, "input stalled after accumulate beat")

endmodule

bind neuron_mac_inverse_square nmis_chk u_nmis_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
